@@ rtl/abu_pkg.sv @@
// Shared types, codes and constants of the access breakpoint unit.
package abu_pkg;

   localparam int NUM_SLOTS_DEF = 5;

   localparam int CMD_W  = 2;
   localparam int KIND_W = 2;
   localparam int ADDR_W = 16;
   localparam int SLOT_W = 3;
   localparam int FLAG_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_CHECK  = 2'd2
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_EXEC  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KIND_W-1:0] access_kind;
      logic [ADDR_W-1:0] address;
      logic [SLOT_W-1:0] slot_number;
   } abu_req_type;

   typedef struct packed {
      logic              hit;
      logic              table_full;
      logic [SLOT_W-1:0] slot_taken;
   } abu_rsp_type;

   function automatic logic [FLAG_W-1:0] kind_flag(input logic [KIND_W-1:0] kind);
      logic [FLAG_W-1:0] flag;
      case (kind)
         KIND_READ:  flag = 3'b001;
         KIND_WRITE: flag = 3'b010;
         KIND_EXEC:  flag = 3'b100;
         default:    flag = '0;
      endcase
      return flag;
   endfunction

endpackage

@@ rtl/abu_req_if.sv @@
// Request channel interface: command, kind, address and slot number.
interface abu_req_if
   import abu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [KIND_W-1:0] access_kind;
   logic [ADDR_W-1:0] address;
   logic [SLOT_W-1:0] slot_number;

   modport source (output valid, command, access_kind, address, slot_number, input ready);
   modport sink   (input valid, command, access_kind, address, slot_number, output ready);
endinterface

@@ rtl/abu_rsp_if.sv @@
// Response channel interface: hit, table full and slot taken.
interface abu_rsp_if
   import abu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic              table_full;
   logic [SLOT_W-1:0] slot_taken;

   modport source (output valid, hit, table_full, slot_taken, input ready);
   modport sink   (input valid, hit, table_full, slot_taken, output ready);
endinterface

@@ rtl/abu_slot_table.sv @@
// Breakpoint slot table: add, delete, and a combinational check against all slots.
module abu_slot_table
   import abu_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  abu_req_type req,
   output abu_rsp_type rsp
);

   logic [ADDR_W-1:0] addr_ff  [NUM_SLOTS];
   logic [ADDR_W-1:0] addr_in  [NUM_SLOTS];
   logic [FLAG_W-1:0] flags_ff [NUM_SLOTS];
   logic [FLAG_W-1:0] flags_in [NUM_SLOTS];
   logic [FLAG_W-1:0] mask;
   logic              found;

   always_comb begin
      mask     = kind_flag(req.access_kind);
      addr_in  = addr_ff;
      flags_in = flags_ff;
      rsp      = '0;
      found    = 1'b0;
      case (cmd_type'(req.command))
         CMD_ADD: begin
            if (mask != '0) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!found && flags_ff[i] == '0) begin
                     found          = 1'b1;
                     addr_in[i]     = req.address;
                     flags_in[i]    = mask;
                     rsp.slot_taken = SLOT_W'(i + 1);
                  end
               end
               rsp.table_full = !found;
            end
         end
         CMD_DELETE: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (req.slot_number == SLOT_W'(i + 1)) begin
                  addr_in[i]  = '0;
                  flags_in[i] = '0;
               end
            end
         end
         CMD_CHECK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if ((flags_ff[i] & mask) != '0 && addr_ff[i] == req.address) begin
                  rsp.hit = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '{default: '0};
      end else if (enable) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         addr_ff <= addr_in;
      end
   end

endmodule

@@ rtl/access_breakpoint_unit.sv @@
// Top level of the access breakpoint unit.
// Takes one command item per cycle (add, delete or check) and returns one response
// item for each: the item is registered, resolved against the slot table while
// the table updates, and the response is registered. Throughput is one item per
// cycle, set by the read-modify-write of the slot table; a stalled response stalls
// the input only once both registers are full. Reset frees all slots at once.
module access_breakpoint_unit
   import abu_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input logic       clock,
   input logic       reset,
   abu_req_if.sink   req_chan,
   abu_rsp_if.source rsp_chan
);

   logic        req_valid_ff;
   logic        req_valid_in;
   abu_req_type req_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   abu_rsp_type rsp_ff;
   abu_rsp_type table_rsp;
   logic        advance;
   logic        fire;
   logic        accept;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !reset && (!req_valid_ff || advance);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.command     <= req_chan.command;
         req_ff.access_kind <= req_chan.access_kind;
         req_ff.address     <= req_chan.address;
         req_ff.slot_number <= req_chan.slot_number;
      end
      if (fire) begin
         rsp_ff <= table_rsp;
      end
   end

   abu_slot_table #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_slot_table (
      .clock (clock),
      .reset (reset),
      .enable(fire),
      .req   (req_ff),
      .rsp   (table_rsp)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_ff.hit;
   assign rsp_chan.table_full = rsp_ff.table_full;
   assign rsp_chan.slot_taken = rsp_ff.slot_taken;

endmodule

@@ rtl/abu_checker.sv @@
// Port-level assertions for the access breakpoint unit, bound to the top level.
module abu_checker
   import abu_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_hit,
   input logic              rsp_table_full,
   input logic [SLOT_W-1:0] rsp_slot_taken
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hit_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_table_full && rsp_slot_taken == '0)
      else $error("hit reported together with add result");

   a_add_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slot_taken <= SLOT_W'(NUM_SLOTS)
                    && !(rsp_table_full && rsp_slot_taken != '0))
      else $error("inconsistent add result");

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
                                  && $stable({rsp_hit, rsp_table_full, rsp_slot_taken}))
      else $error("stalled response changed");

endmodule

bind access_breakpoint_unit abu_checker #(
   .NUM_SLOTS(NUM_SLOTS)
) u_abu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_hit       (rsp_chan.hit),
   .rsp_table_full(rsp_chan.table_full),
   .rsp_slot_taken(rsp_chan.slot_taken)
);
